// ===== rtl/b2te_pkg.sv =====
// Shared types and constants for the base-2^N text encoder.
`timescale 1ns / 1ps
`default_nettype none

package b2te_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYMBOL_BITS = 2'd0;
    localparam logic [1:0] CFG_PAD_CHAR    = 2'd1;
    localparam logic [1:0] CFG_PAD_BLOCK   = 2'd2;

    localparam int MAX_SYMBOL_BITS = 7;
    localparam int MAX_PAD_BLOCK   = 32;

    localparam int CHAR_W = 8;   // byte and character width
    localparam int SYM_W  = 3;   // symbol_bits register width
    localparam int BLK_W  = 6;   // pad_block register width
    localparam int ACC_W  = 14;  // bit accumulator
    localparam int CNT_W  = 4;   // pending bit count
    localparam int EMIT_W = 5;   // characters emitted modulo the block
    localparam int ADDR_W = 7;   // alphabet address
    localparam int DEPTH  = 128; // alphabet entries

    localparam logic [SYM_W-1:0] SYM_RESET   = 3'd6;
    localparam logic [CHAR_W-1:0] PAD_RESET  = 8'd61;
    localparam logic [BLK_W-1:0] BLK_RESET   = 6'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EMIT,
        ST_FLUSH,
        ST_PAD
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/base2n_text_encoder_unit.sv =====
// Top level of the base-2^N text encoder: alphabet memory, bit accumulator and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Encodes a byte stream into base-2^N text (N = 1..7) through a loadable
// alphabet held in a 128-entry synchronous memory. A data item is taken in
// idle and then yields one character per cycle while the sink keeps up
// (8 div N or 8 div N + 1 characters); every encoded character costs one read
// of the single alphabet port, and a two-entry output stage keeps reads
// flowing while a result waits. An end item passes the flush step, which
// issues the flush character only if bits are pending, then the pad step,
// which issues the pad characters and then clears the message state. Alphabet
// loads and ignored kinds leave the encoder in idle. If the pad block was
// lowered in the middle of a message, the next data or end item first passes
// a reduce step bringing the emitted-character count under the new block. New
// items are taken only once the previous item has issued all its characters.
module base2n_text_encoder_unit
    import b2te_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] data_byte, [14:8] table_index, [22:15] table_char, [23] zero
    input  wire logic [23:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]       m_axis_tdata,
    // [0] is_padding
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    // configuration
    logic [SYM_W-1:0]  r_symbol_bits;
    logic [CHAR_W-1:0] r_pad_char;
    logic [BLK_W-1:0]  r_pad_block;

    // message state
    t_state            r_state, n_state;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [EMIT_W-1:0] r_emit, n_emit;
    logic              r_is_end;

    // alphabet memory
    logic [CHAR_W-1:0] r_alpha [DEPTH];
    logic [CHAR_W-1:0] r_mem_q;

    // read in flight and output stage
    logic              r_pend, r_pend_pad, r_pend_last;
    logic              r_out_valid, r_out_pad, r_out_last;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_skid_valid, r_skid_pad, r_skid_last;
    logic [CHAR_W-1:0] r_skid_char;

    logic              w_in_acc, w_out_acc, w_cfg_acc;
    logic [SYM_W-1:0]  w_n;
    logic [ADDR_W-1:0] w_mask;
    logic [CHAR_W-1:0] w_mask_full;
    logic [BLK_W-1:0]  w_blk;
    logic              w_pad_en;
    logic [BLK_W-1:0]  w_mod;
    logic [BLK_W-1:0]  w_e_inc;
    logic [EMIT_W-1:0] w_e_next;
    logic              w_e_big;
    logic              w_cnt_ge_n;
    logic [CNT_W-1:0]  w_cnt_rem;
    logic [ACC_W-1:0]  w_sh_dn, w_sh_up;
    logic [ADDR_W-1:0] w_idx;
    logic [1:0]        w_occ;
    logic              w_can_issue;
    logic              w_issue, w_issue_pad, w_issue_last, w_rd_en;
    logic [CHAR_W-1:0] w_pend_char;

    assign o_cfg_ready   = 1'b1;
    assign w_cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_out_acc     = r_out_valid & m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_pad;
    assign m_axis_tlast  = r_out_last;

    // effective symbol width and block size
    always_comb begin
        if (r_symbol_bits == '0) begin
            w_n = SYM_W'(1);
        end else if (r_symbol_bits > SYM_W'(MAX_SYMBOL_BITS)) begin
            w_n = SYM_W'(MAX_SYMBOL_BITS);
        end else begin
            w_n = r_symbol_bits;
        end
    end

    assign w_mask_full = (CHAR_W'(1) << w_n) - CHAR_W'(1);
    assign w_mask      = w_mask_full[ADDR_W-1:0];

    assign w_blk    = (r_pad_block > BLK_W'(MAX_PAD_BLOCK)) ? BLK_W'(MAX_PAD_BLOCK)
                                                            : r_pad_block;
    assign w_pad_en = (w_blk >= BLK_W'(2));
    assign w_mod    = w_pad_en ? w_blk : BLK_W'(MAX_PAD_BLOCK);

    // emitted count advance; the count is already below the modulus here
    assign w_e_inc  = {1'b0, r_emit} + BLK_W'(1);
    assign w_e_next = (w_e_inc == w_mod) ? '0 : w_e_inc[EMIT_W-1:0];
    assign w_e_big  = ({1'b0, r_emit} >= w_mod);

    // symbol window into the accumulator
    assign w_cnt_ge_n = (r_count >= {1'b0, w_n});
    assign w_cnt_rem  = r_count - {1'b0, w_n};
    assign w_sh_dn    = r_acc >> w_cnt_rem;
    assign w_sh_up    = r_acc << (w_n - r_count[SYM_W-1:0]);
    assign w_idx      = (w_cnt_ge_n ? w_sh_dn[ADDR_W-1:0] : w_sh_up[ADDR_W-1:0]) & w_mask;

    // issue only if the output stage can absorb everything in flight
    assign w_occ       = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, r_pend};
    assign w_can_issue = ((w_occ - {1'b0, w_out_acc}) <= 2'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tuser == KIND_DATA || s_axis_tuser == KIND_END)) begin
                    if (w_e_big) begin
                        n_state = ST_REDUCE;
                    end else if (s_axis_tuser == KIND_END) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_REDUCE: begin
                if (!w_e_big) begin
                    n_state = r_is_end ? ST_FLUSH : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_can_issue && (w_cnt_rem < {1'b0, w_n})) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (r_count == '0 || w_can_issue) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (!(w_pad_en && r_emit != '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and issue control
    always_comb begin
        n_acc        = r_acc;
        n_count      = r_count;
        n_emit       = r_emit;
        w_issue      = 1'b0;
        w_issue_pad  = 1'b0;
        w_issue_last = 1'b0;
        w_rd_en      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tuser == KIND_DATA) begin
                    n_acc   = {r_acc[ACC_W-CHAR_W-1:0], s_axis_tdata[7:0]};
                    n_count = r_count + CNT_W'(CHAR_W);
                end
            end
            ST_REDUCE: begin
                if (w_e_big) begin
                    n_emit = r_emit - w_mod[EMIT_W-1:0];
                end
            end
            ST_EMIT: begin
                if (w_can_issue) begin
                    w_issue      = 1'b1;
                    w_rd_en      = 1'b1;
                    w_issue_last = (w_cnt_rem < {1'b0, w_n});
                    n_count      = w_cnt_rem;
                    n_emit       = w_e_next;
                end
            end
            ST_FLUSH: begin
                if (r_count != '0 && w_can_issue) begin
                    w_issue      = 1'b1;
                    w_rd_en      = 1'b1;
                    w_issue_last = !(w_pad_en && w_e_next != '0);
                    n_count      = '0;
                    n_emit       = w_e_next;
                end
            end
            ST_PAD: begin
                if (w_pad_en && r_emit != '0) begin
                    if (w_can_issue) begin
                        w_issue      = 1'b1;
                        w_issue_pad  = 1'b1;
                        w_issue_last = (w_e_next == '0);
                        n_emit       = w_e_next;
                    end
                end else begin
                    // message done: clear for the next one
                    n_acc   = '0;
                    n_count = '0;
                    n_emit  = '0;
                end
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bits <= SYM_RESET;
            r_pad_char    <= PAD_RESET;
            r_pad_block   <= BLK_RESET;
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_SYMBOL_BITS: r_symbol_bits <= i_cfg_data[SYM_W-1:0];
                CFG_PAD_CHAR:    r_pad_char    <= i_cfg_data;
                CFG_PAD_BLOCK:   r_pad_block   <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    // control and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acc    <= '0;
            r_count  <= '0;
            r_emit   <= '0;
            r_is_end <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_emit  <= n_emit;
            if (w_in_acc) begin
                r_is_end <= (s_axis_tuser == KIND_END);
            end
        end
    end

    // alphabet memory: load in idle, read per encoded character
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == KIND_LOAD) begin
            r_alpha[s_axis_tdata[14:8]] <= s_axis_tdata[22:15];
        end
        if (w_rd_en) begin
            r_mem_q <= r_alpha[w_idx];
        end
    end

    assign w_pend_char = r_pend_pad ? r_pad_char : r_mem_q;

    // output stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_out_acc || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= r_pend;
                end
            end else if (r_pend) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_pad  <= w_issue_pad;
            r_pend_last <= w_issue_last;
        end
        if (w_out_acc || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_char <= r_skid_char;
                r_out_pad  <= r_skid_pad;
                r_out_last <= r_skid_last;
            end else begin
                r_out_char <= w_pend_char;
                r_out_pad  <= r_pend_pad;
                r_out_last <= r_pend_last;
            end
        end else if (r_pend) begin
            r_skid_char <= w_pend_char;
            r_skid_pad  <= r_pend_pad;
            r_skid_last <= r_pend_last;
        end
    end

endmodule

`default_nettype wire
